### rtl/lumg_pkg.sv
// Shared constants for the lens undistortion map generator.
`timescale 1ns / 1ps
`default_nettype none
package lumg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;

  localparam int CENTER_W   = 16;
  localparam int INV_W      = 32;
  localparam int COEF_W     = 20;
  localparam int GAIN_W     = 20;
  localparam int OUT_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y      = 3'd7;

  localparam logic [CENTER_W-1:0]      RST_CENTER_X    = 16'd11566;
  localparam logic [CENTER_W-1:0]      RST_CENTER_Y    = 16'd8660;
  localparam logic [INV_W-1:0]         RST_INV_FOCAL_X = 32'd2743862;
  localparam logic [INV_W-1:0]         RST_INV_FOCAL_Y = 32'd2748499;
  localparam logic signed [COEF_W-1:0] RST_RADIAL_K1   = -20'sd96141;
  localparam logic signed [COEF_W-1:0] RST_RADIAL_K2   = 20'sd67895;
  localparam logic [GAIN_W-1:0]        RST_GAIN_X      = 20'd477663;
  localparam logic [GAIN_W-1:0]        RST_GAIN_Y      = 20'd476856;

endpackage
`default_nettype wire

### rtl/lens_undistort_map_gen_top.sv
// Top level of the lens undistortion map generator pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Radial undistortion map generator. Each input transaction carries an output pixel
// position and returns the source position to sample, signed Q15.4 by default
// (FRAC_BITS fraction bits), saturated to 20 bits. The datapath is a fifteen-stage
// pipeline in which every multiplier is followed by a register, and one transaction
// is accepted per cycle while out_ready is high.
// When the output holds a result and out_ready is low, the whole pipeline holds.
// Configuration registers may only be written while the pipeline is empty.
module lens_undistort_map_gen_top #(
  parameter int COORD_BITS = lumg_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lumg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [lumg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [lumg_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [COORD_BITS-1:0]                  in_pixel_column,
  input  wire logic [COORD_BITS-1:0]                  in_pixel_row,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [lumg_pkg::OUT_W-1:0]           out_source_x,
  output logic signed [lumg_pkg::OUT_W-1:0]           out_source_y
);

  import lumg_pkg::*;

  localparam int NSTG = 15;
  localparam int D_W  = ((COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W) + 1;
  localparam int PW   = D_W + INV_W + 1;
  localparam int SH   = 24 - FRAC_BITS;

  localparam logic [27:0]        R2_MAX   = 28'hFFFFFFF;
  localparam logic signed [63:0] HALF15   = 64'sd32768;
  localparam logic signed [63:0] HALF19   = 64'sd524288;
  localparam logic signed [63:0] HALF_OUT = 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0] P_ONE    = 64'sd4294967296;
  localparam logic signed [63:0] POLY_LIM = 64'sd2147483648;
  localparam logic signed [63:0] Q_LIM    = 64'sd1099511627776;
  localparam logic signed [63:0] O_MAX    = 64'sd524287;
  localparam logic signed [63:0] O_MIN    = -64'sd524288;

  logic [CENTER_W-1:0]      center_r [2];
  logic [INV_W-1:0]         inv_r    [2];
  logic [GAIN_W-1:0]        gain_r   [2];
  logic signed [COEF_W-1:0] k1_r;
  logic signed [COEF_W-1:0] k2_r;

  logic [NSTG-1:0] vld_r;
  logic            adv;

  logic [COORD_BITS-1:0] pix [2];

  logic signed [D_W-1:0]  s1_d_r     [2];
  logic signed [D_W-1:0]  s1_d_nxt   [2];
  logic signed [PW-1:0]   s2_prod_r  [2];
  logic signed [PW-1:0]   s2_prod_nxt[2];
  logic signed [31:0]     s3_n_r     [2];
  logic signed [31:0]     s3_n_nxt   [2];
  logic signed [63:0]     s4_sq_r    [2];
  logic signed [63:0]     s4_sq_nxt  [2];
  logic signed [31:0]     s4_n_r     [2];
  logic [27:0]            s5_r2_r;
  logic [27:0]            s5_r2_nxt;
  logic signed [31:0]     s5_n_r     [2];
  logic [55:0]            s6_r4p_r;
  logic [55:0]            s6_r4p_nxt;
  logic signed [48:0]     s6_k1r2_r;
  logic signed [48:0]     s6_k1r2_nxt;
  logic signed [31:0]     s6_n_r     [2];
  logic [40:0]            s7_r4_r;
  logic [40:0]            s7_r4_nxt;
  logic signed [48:0]     s7_k1r2_r;
  logic signed [31:0]     s7_n_r     [2];
  logic signed [41:0]     s8_k2lo_r;
  logic signed [41:0]     s8_k2lo_nxt;
  logic signed [40:0]     s8_k2hi_r;
  logic signed [40:0]     s8_k2hi_nxt;
  logic signed [48:0]     s8_k1r2_r;
  logic signed [31:0]     s8_n_r     [2];
  logic signed [63:0]     s9_p32_r;
  logic signed [63:0]     s9_p32_nxt;
  logic signed [31:0]     s9_n_r     [2];
  logic signed [32:0]     s10_poly_r;
  logic signed [32:0]     s10_poly_nxt;
  logic signed [31:0]     s10_n_r    [2];
  logic signed [64:0]     s11_np_r   [2];
  logic signed [64:0]     s11_np_nxt [2];
  logic signed [41:0]     s12_q_r    [2];
  logic signed [41:0]     s12_q_nxt  [2];
  logic signed [42:0]     s13_glo_r  [2];
  logic signed [42:0]     s13_glo_nxt[2];
  logic signed [41:0]     s13_ghi_r  [2];
  logic signed [41:0]     s13_ghi_nxt[2];
  logic signed [63:0]     s14_acc_r  [2];
  logic signed [63:0]     s14_acc_nxt[2];
  logic signed [OUT_W-1:0] out_src_r  [2];
  logic signed [OUT_W-1:0] out_src_nxt[2];

  logic [62:0]        r2_sum;
  logic [56:0]        r4_sum;
  logic signed [63:0] rnd_p;
  logic signed [63:0] t_p;
  logic signed [63:0] t_w    [2];
  logic signed [63:0] rnd_n  [2];
  logic signed [63:0] t_np   [2];
  logic signed [63:0] rnd_q  [2];
  logic signed [63:0] t_q    [2];
  logic signed [63:0] rnd_o  [2];
  logic signed [63:0] t_o    [2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= RST_CENTER_X;
      center_r[1] <= RST_CENTER_Y;
      inv_r[0]    <= RST_INV_FOCAL_X;
      inv_r[1]    <= RST_INV_FOCAL_Y;
      k1_r        <= RST_RADIAL_K1;
      k2_r        <= RST_RADIAL_K2;
      gain_r[0]   <= RST_GAIN_X;
      gain_r[1]   <= RST_GAIN_Y;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:    center_r[0] <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:    center_r[1] <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X: inv_r[0]    <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y: inv_r[1]    <= cfg_data[INV_W-1:0];
        REG_RADIAL_K1:   k1_r        <= $signed(cfg_data[COEF_W-1:0]);
        REG_RADIAL_K2:   k2_r        <= $signed(cfg_data[COEF_W-1:0]);
        REG_GAIN_X:      gain_r[0]   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Y:      gain_r[1]   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = out_ready | ~vld_r[NSTG-1];
  assign in_ready  = adv;
  assign out_valid = vld_r[NSTG-1];

  assign pix[0] = in_pixel_column;
  assign pix[1] = in_pixel_row;

  always_comb begin
    r2_sum       = {1'b0, s4_sq_r[0][61:0]} + {1'b0, s4_sq_r[1][61:0]} + 63'd32768;
    s5_r2_nxt    = (|r2_sum[62:44]) ? R2_MAX : r2_sum[43:16];
    s6_r4p_nxt   = s5_r2_r * s5_r2_r;
    s6_k1r2_nxt  = k1_r * $signed({1'b0, s5_r2_r});
    r4_sum       = {1'b0, s6_r4p_r} + 57'd32768;
    s7_r4_nxt    = r4_sum[56:16];
    s8_k2lo_nxt  = k2_r * $signed({1'b0, s7_r4_r[20:0]});
    s8_k2hi_nxt  = k2_r * $signed({1'b0, s7_r4_r[40:21]});
    s9_p32_nxt   = P_ONE + 64'(s8_k1r2_r) + (64'(s8_k2hi_r) <<< 21) + 64'(s8_k2lo_r);
    rnd_p        = s9_p32_r + HALF15 - 64'(s9_p32_r[63]);
    t_p          = rnd_p >>> 16;
    if (t_p > POLY_LIM) begin
      s10_poly_nxt = POLY_LIM[32:0];
    end else if (t_p < -POLY_LIM) begin
      s10_poly_nxt = -33'sd2147483648;
    end else begin
      s10_poly_nxt = t_p[32:0];
    end
    for (int a = 0; a < 2; a++) begin
      s1_d_nxt[a]    = $signed(D_W'({pix[a], 4'b0000}) - D_W'(center_r[a]));
      s2_prod_nxt[a] = s1_d_r[a] * $signed({1'b0, inv_r[a]});
      t_w[a]         = 64'(s2_prod_r[a]);
      rnd_n[a]       = t_w[a] + HALF19 - 64'(t_w[a][63]);
      s3_n_nxt[a]    = 32'(rnd_n[a] >>> 20);
      s4_sq_nxt[a]   = s3_n_r[a] * s3_n_r[a];
      s11_np_nxt[a]  = s10_n_r[a] * s10_poly_r;
      t_np[a]        = 64'(s11_np_r[a]);
      rnd_q[a]       = t_np[a] + HALF15 - 64'(t_np[a][63]);
      t_q[a]         = rnd_q[a] >>> 16;
      if (t_q[a] > Q_LIM) begin
        s12_q_nxt[a] = Q_LIM[41:0];
      end else if (t_q[a] < -Q_LIM) begin
        s12_q_nxt[a] = -42'sd1099511627776;
      end else begin
        s12_q_nxt[a] = t_q[a][41:0];
      end
      s13_glo_nxt[a] = $signed({1'b0, gain_r[a]}) * $signed({1'b0, s12_q_r[a][20:0]});
      s13_ghi_nxt[a] = $signed({1'b0, gain_r[a]}) * $signed(s12_q_r[a][41:21]);
      s14_acc_nxt[a] = (64'(s13_ghi_r[a]) <<< 21) + 64'(s13_glo_r[a])
                       + $signed(64'(center_r[a]) << 20);
      rnd_o[a]       = s14_acc_r[a] + HALF_OUT - 64'(s14_acc_r[a][63]);
      t_o[a]         = rnd_o[a] >>> SH;
      if (t_o[a] > O_MAX) begin
        out_src_nxt[a] = O_MAX[OUT_W-1:0];
      end else if (t_o[a] < O_MIN) begin
        out_src_nxt[a] = O_MIN[OUT_W-1:0];
      end else begin
        out_src_nxt[a] = t_o[a][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r2_r    <= s5_r2_nxt;
      s6_r4p_r   <= s6_r4p_nxt;
      s6_k1r2_r  <= s6_k1r2_nxt;
      s7_r4_r    <= s7_r4_nxt;
      s7_k1r2_r  <= s6_k1r2_r;
      s8_k2lo_r  <= s8_k2lo_nxt;
      s8_k2hi_r  <= s8_k2hi_nxt;
      s8_k1r2_r  <= s7_k1r2_r;
      s9_p32_r   <= s9_p32_nxt;
      s10_poly_r <= s10_poly_nxt;
      for (int a = 0; a < 2; a++) begin
        s1_d_r[a]    <= s1_d_nxt[a];
        s2_prod_r[a] <= s2_prod_nxt[a];
        s3_n_r[a]    <= s3_n_nxt[a];
        s4_sq_r[a]   <= s4_sq_nxt[a];
        s4_n_r[a]    <= s3_n_r[a];
        s5_n_r[a]    <= s4_n_r[a];
        s6_n_r[a]    <= s5_n_r[a];
        s7_n_r[a]    <= s6_n_r[a];
        s8_n_r[a]    <= s7_n_r[a];
        s9_n_r[a]    <= s8_n_r[a];
        s10_n_r[a]   <= s9_n_r[a];
        s11_np_r[a]  <= s11_np_nxt[a];
        s12_q_r[a]   <= s12_q_nxt[a];
        s13_glo_r[a] <= s13_glo_nxt[a];
        s13_ghi_r[a] <= s13_ghi_nxt[a];
        s14_acc_r[a] <= s14_acc_nxt[a];
        out_src_r[a] <= out_src_nxt[a];
      end
    end
  end

  assign out_source_x = out_src_r[0];
  assign out_source_y = out_src_r[1];

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r == $past(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_r2_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> s5_r2_r <= R2_MAX)
    else $error("squared radius exceeds its saturation limit");

  a_poly_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[9] |-> (64'(s10_poly_r) <= POLY_LIM) && (64'(s10_poly_r) >= -POLY_LIM))
    else $error("radial factor outside its saturation range");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[11] |-> (64'(s12_q_r[0]) <= Q_LIM) && (64'(s12_q_r[0]) >= -Q_LIM))
    else $error("scaled coordinate outside its saturation range");

endmodule
`default_nettype wire

### verif/lens_undistort_map_gen_top_tb.sv
// Self-checking testbench for the lens undistortion map generator top level.
`timescale 1ns / 1ps
module lens_undistort_map_gen_top_tb;
  import lumg_pkg::*;

  localparam int     COORD_W        = COORD_BITS_DEF;
  localparam int     PIPE_LATENCY   = 15;
  localparam int     DRAIN_MARGIN   = PIPE_LATENCY + 10;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam longint R2_CEIL        = (64'sd1 <<< 28) - 1;
  localparam longint POLY_LIM       = 64'sd1 <<< 31;
  localparam longint SCALED_LIM     = 64'sd1 <<< 40;
  localparam longint OUT_LIM        = 64'sd1 <<< (OUT_W - 1);

  class lens_map_scoreboard;
    logic [CENTER_W-1:0]        ctr_x, ctr_y;
    logic [INV_W-1:0]           inv_fx, inv_fy;
    logic signed [COEF_W-1:0]   k1, k2;
    logic [GAIN_W-1:0]          gn_x, gn_y;
    logic signed [OUT_W-1:0]    src_x_q[$];
    logic signed [OUT_W-1:0]    src_y_q[$];
    int                         errors;

    function new();
      errors = 0;
      ctr_x  = RST_CENTER_X;
      ctr_y  = RST_CENTER_Y;
      inv_fx = RST_INV_FOCAL_X;
      inv_fy = RST_INV_FOCAL_Y;
      k1     = RST_RADIAL_K1;
      k2     = RST_RADIAL_K2;
      gn_x   = RST_GAIN_X;
      gn_y   = RST_GAIN_Y;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CENTER_X:    ctr_x  = data[CENTER_W-1:0];
        REG_CENTER_Y:    ctr_y  = data[CENTER_W-1:0];
        REG_INV_FOCAL_X: inv_fx = data[INV_W-1:0];
        REG_INV_FOCAL_Y: inv_fy = data[INV_W-1:0];
        REG_RADIAL_K1:   k1     = data[COEF_W-1:0];
        REG_RADIAL_K2:   k2     = data[COEF_W-1:0];
        REG_GAIN_X:      gn_x   = data[GAIN_W-1:0];
        REG_GAIN_Y:      gn_y   = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Rounds half away from zero while dropping sh fraction bits.
    function longint round_away(longint v, int sh);
      longint unsigned half;
      longint unsigned mag;
      half = 64'd1 << (sh - 1);
      if (v < 0) begin
        mag = $unsigned(-v);
        return -$signed((mag + half) >> sh);
      end
      mag = $unsigned(v);
      return $signed((mag + half) >> sh);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function logic signed [OUT_W-1:0] place(longint n, longint poly, longint gain,
                                            longint center);
      longint q;
      longint acc;
      longint o;
      q   = clamp(round_away(n * poly, 16), -SCALED_LIM, SCALED_LIM);
      acc = gain * q + (center <<< 20);
      o   = clamp(round_away(acc, 24 - FRAC_BITS_DEF), -OUT_LIM, OUT_LIM - 1);
      return o[OUT_W-1:0];
    endfunction

    function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      longint nx, ny, r2, r4, p32, poly;
      nx   = round_away((longint'(col) * 16 - longint'(ctr_x)) * longint'(inv_fx), 20);
      ny   = round_away((longint'(row) * 16 - longint'(ctr_y)) * longint'(inv_fy), 20);
      r2   = clamp(round_away(nx * nx + ny * ny, 16), 0, R2_CEIL);
      r4   = round_away(r2 * r2, 16);
      p32  = (64'sd1 <<< 32) + longint'(k1) * r2 + longint'(k2) * r4;
      poly = clamp(round_away(p32, 16), -POLY_LIM, POLY_LIM);
      src_x_q.push_back(place(nx, poly, longint'(gn_x), longint'(ctr_x)));
      src_y_q.push_back(place(ny, poly, longint'(gn_y), longint'(ctr_y)));
    endfunction

    function void check_position(logic signed [OUT_W-1:0] x, logic signed [OUT_W-1:0] y);
      logic signed [OUT_W-1:0] want_x;
      logic signed [OUT_W-1:0] want_y;
      if (src_x_q.size() == 0) begin
        $display("%0t: unexpected result transaction (%0d, %0d)", $time, x, y);
        errors++;
        return;
      end
      want_x = src_x_q.pop_front();
      want_y = src_y_q.pop_front();
      if (x !== want_x) begin
        $display("%0t: source_x mismatch, expected %0d, actual %0d", $time, want_x, x);
        errors++;
      end
      if (y !== want_y) begin
        $display("%0t: source_y mismatch, expected %0d, actual %0d", $time, want_y, y);
        errors++;
      end
    endfunction

    function int pending();
      return src_x_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [COORD_W-1:0]       in_pixel_column;
  logic [COORD_W-1:0]       in_pixel_row;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [OUT_W-1:0]  out_source_x;
  logic signed [OUT_W-1:0]  out_source_y;
  int                       quiet_cycles;

  lens_map_scoreboard sb = new();

  lens_undistort_map_gen_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_column (in_pixel_column),
    .in_pixel_row    (in_pixel_row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_source_x    (out_source_x),
    .out_source_y    (out_source_y)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COORD_W'($urandom);
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper bits beyond each register's width carry random junk.
  task automatic load_lens(logic [31:0] cx, logic [31:0] cy, logic [31:0] ifx,
                           logic [31:0] ify, logic [31:0] c1, logic [31:0] c2,
                           logic [31:0] gx, logic [31:0] gy);
    write_register(REG_CENTER_X, {16'($urandom), cx[15:0]});
    write_register(REG_CENTER_Y, {16'($urandom), cy[15:0]});
    write_register(REG_INV_FOCAL_X, ifx);
    write_register(REG_INV_FOCAL_Y, ify);
    write_register(REG_RADIAL_K1, {12'($urandom), c1[19:0]});
    write_register(REG_RADIAL_K2, {12'($urandom), c2[19:0]});
    write_register(REG_GAIN_X, {12'($urandom), gx[19:0]});
    write_register(REG_GAIN_Y, {12'($urandom), gy[19:0]});
  endtask

  task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row, bit burst);
    int gap;
    in_valid        <= 1'b1;
    in_pixel_column <= col;
    in_pixel_row    <= row;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(col, row);
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_MARGIN) @(posedge clk);
  endtask

  task automatic send_corners();
    send_pixel('0, '0, 1'b0);
    send_pixel('1, '1, 1'b0);
    send_pixel('0, '1, 1'b0);
    send_pixel('1, '0, 1'b0);
  endtask

  task automatic run_random(int count, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      send_pixel(pick_coord(), pick_coord(), ((i / 48) % 4) == 3);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_pixel_column = '0;
    in_pixel_row    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_corners();
    send_pixel(12'd722, 12'd541, 1'b0);
    send_pixel(12'd723, 12'd541, 1'b0);
    send_pixel(12'hAAA, 12'h555, 1'b0);
    send_pixel(12'h555, 12'hAAA, 1'b0);
    send_pixel(12'd1, 12'd1, 1'b0);
    send_pixel(12'd2048, 12'd2048, 1'b0);
    run_random(250, 120);

    settle();
    load_lens($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(32'h0010_0000, 32'h0100_0000),
              $urandom_range(32'h0010_0000, 32'h0100_0000),
              $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
              $urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF));
    run_random(250, -1);

    settle();
    load_lens(32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFFF, 32'h80000, 32'hFFFFF, 32'hFFFFF);
    send_corners();
    run_random(150, -1);

    settle();
    load_lens(32'h0, 32'h0, 32'h0, 32'h0, 32'h80000, 32'h80000, 32'h0, 32'h0);
    send_corners();
    run_random(100, -1);

    for (int k = 0; k < 2; k++) begin
      settle();
      load_lens($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
      run_random(150, -1);
    end

    settle();
    load_lens(32'(RST_CENTER_X), 32'(RST_CENTER_Y), RST_INV_FOCAL_X, RST_INV_FOCAL_Y,
              32'(RST_RADIAL_K1), 32'(RST_RADIAL_K2), 32'(RST_GAIN_X), 32'(RST_GAIN_Y));
    run_random(150, 75);

    settle();
    if (sb.errors == 0) begin
      $display("lens_undistort_map_gen_top test passed");
    end else begin
      $display("lens_undistort_map_gen_top test failed");
    end
    $finish;
  end

  initial begin
    int          stall_left;
    int unsigned cyc;
    out_ready  = 1'b0;
    stall_left = 0;
    cyc        = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_position(out_source_x, out_source_y);
      cyc++;
      if ((cyc / 300) % 4 == 1) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(1'b0) : 0;
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_n && quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lens_undistort_map_gen_top test failed");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
